FILE: rtl/bmp_lsb_payload_extractor_unit_assert.svh
// assertion macros used by the rtl
`ifndef BMP_LSB_PAYLOAD_EXTRACTOR_UNIT_ASSERT_SVH
`define BMP_LSB_PAYLOAD_EXTRACTOR_UNIT_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define BLPE_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("blpe assertion failed");

// consequent must hold in the same cycle as the antecedent
`define BLPE_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("blpe assertion failed");

// consequent must hold in the cycle after the antecedent
`define BLPE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("blpe assertion failed");

`endif

FILE: rtl/blpe_pkg.sv
// types, codes and helpers for the bmp lsb payload extractor
package blpe_pkg;

    // parser phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_SKIP    = 3'd1;
    localparam logic [2:0] PH_MAGIC   = 3'd2;
    localparam logic [2:0] PH_EXTLEN  = 3'd3;
    localparam logic [2:0] PH_EXT     = 3'd4;
    localparam logic [2:0] PH_FILELEN = 3'd5;
    localparam logic [2:0] PH_DATA    = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_EXT   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    // configuration register indexes
    localparam logic [0:0] CFG_MAGIC_LENGTH = 1'd0;
    localparam logic [0:0] CFG_MAGIC_CHARS  = 1'd1;

    localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
    localparam logic [63:0] MAGIC_CHARS_RST  = 64'd10787;
    localparam logic [3:0]  MAGIC_MAX        = 4'd8;

    localparam logic [31:0] MIN_OFFSET    = 32'd14;
    localparam logic [31:0] OFF_FIRST_POS = 32'd10;
    localparam logic [31:0] OFF_LAST_POS  = 32'd13;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic [1:0] result_kind;
        logic       is_last;
    } res_t;

    // a length with the top bit set counts as zero
    function automatic logic [30:0] length_of(input logic [31:0] v);
        return v[31] ? 31'd0 : v[30:0];
    endfunction

endpackage

FILE: rtl/bmp_lsb_payload_extractor_unit.sv
// top level of the bmp lsb payload extractor
//
// Takes a bmp file one byte per item and recovers the payload hidden in the
// least significant bits of its pixel data. Bytes 10 to 13 give the
// little-endian pixel-data offset (values below 14 are taken as 14); from
// that byte on, bit 0 of every byte is a carrier bit, gathered msb first.
// Eight bits form a character, thirty-two a length. The magic signature
// (cfg registers 0 and 1) is checked first; a mismatch yields one kind-2
// result with tlast. Then the extension length and its characters (kind 0)
// follow, then the data length and the data characters (kind 1, the last
// one with tlast). Empty data yields one kind-3 result with tlast. A length
// with bit 31 set counts as zero. After the end, bytes are dropped until an
// item with s_tuser set, which restarts parsing at byte zero. Each item
// yields zero or one result. The block takes one item per clock while
// m_tready is high: an input register feeds a single pass of parse logic
// into the result register. Config is to be written only while idle; the
// user is bound by this, and the block itself does not enforce it.
`include "bmp_lsb_payload_extractor_unit_assert.svh"

module bmp_lsb_payload_extractor_unit
    import blpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] carrier_byte
    input  logic [0:0]  s_tuser,   // [0] file_start
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] decoded_byte
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    // configuration registers
    logic [3:0]  magic_len_reg;
    logic [63:0] magic_chars_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    // parser state
    logic [2:0]  phase_reg,     phase_next;
    logic [31:0] byte_pos_reg,  byte_pos_next;
    logic [31:0] pix_off_reg,   pix_off_next;
    logic [31:0] acc_reg,       acc_next;
    logic [4:0]  bit_cnt_reg,   bit_cnt_next;
    logic [30:0] remain_reg,    remain_next;
    logic [3:0]  magic_idx_reg, magic_idx_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    res_t        res_reg,       res_next;

    logic        fire;

    // the parse stage moves when the result slot is free or being emptied
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg.decoded_byte;
    assign m_tuser  = res_reg.result_kind;
    assign m_tlast  = res_reg.is_last;

    // config write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_len_reg   <= MAGIC_LENGTH_RST;
            magic_chars_reg <= MAGIC_CHARS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAGIC_LENGTH: magic_len_reg   <= cfg_wdata[3:0];
                CFG_MAGIC_CHARS:  magic_chars_reg <= cfg_wdata;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    // single pass parse of the registered byte
    always_comb begin
        logic [3:0]  sig_len;
        logic [31:0] acc_sh;
        logic        grp_done;
        logic [4:0]  need_m1;
        logic [7:0]  want;
        logic        in_bit;

        phase_next     = phase_reg;
        byte_pos_next  = byte_pos_reg;
        pix_off_next   = pix_off_reg;
        acc_next       = acc_reg;
        bit_cnt_next   = bit_cnt_reg;
        remain_next    = remain_reg;
        magic_idx_next = magic_idx_reg;
        out_valid_next = 1'b0;
        res_next       = '{decoded_byte: 8'd0, result_kind: KIND_EXT, is_last: 1'b0};
        in_bit         = in_byte_reg[0];

        // a file start clears the parser and the byte counts as byte zero
        if (in_start_reg) begin
            phase_next     = PH_HEADER;
            byte_pos_next  = 32'd0;
            pix_off_next   = 32'd0;
            acc_next       = 32'd0;
            bit_cnt_next   = 5'd0;
            remain_next    = 31'd0;
            magic_idx_next = 4'd0;
        end

        sig_len = (magic_len_reg > MAGIC_MAX) ? MAGIC_MAX : magic_len_reg;

        if (phase_next == PH_HEADER) begin
            // collect the little-endian pixel offset
            if (byte_pos_next >= OFF_FIRST_POS && byte_pos_next <= OFF_LAST_POS) begin
                pix_off_next = pix_off_next |
                    (32'(in_byte_reg) << {byte_pos_next[1:0] - 2'd2, 3'b000});
            end
            if (byte_pos_next >= OFF_LAST_POS) begin
                if (pix_off_next < MIN_OFFSET) begin
                    pix_off_next = MIN_OFFSET;
                end
                phase_next = PH_SKIP;
            end
        end else begin
            if (phase_next == PH_SKIP && byte_pos_next == pix_off_next) begin
                phase_next     = PH_MAGIC;
                magic_idx_next = 4'd0;
                bit_cnt_next   = 5'd0;
                acc_next       = 32'd0;
            end
            // signature shorter than what has been checked: move on
            if (phase_next == PH_MAGIC && magic_idx_next >= sig_len) begin
                phase_next   = PH_EXTLEN;
                bit_cnt_next = 5'd0;
                acc_next     = 32'd0;
            end
        end

        acc_sh   = {acc_next[30:0], in_bit};
        need_m1  = (phase_next == PH_EXTLEN || phase_next == PH_FILELEN) ? 5'd31 : 5'd7;
        grp_done = bit_cnt_next >= need_m1;
        want     = magic_chars_reg[{magic_idx_next[2:0], 3'b000} +: 8];

        if (phase_reg != PH_HEADER || in_start_reg) begin
            if (!(phase_next == PH_HEADER || phase_next == PH_SKIP ||
                  phase_next == PH_DONE)) begin
                acc_next     = acc_sh;
                bit_cnt_next = grp_done ? 5'd0 : bit_cnt_next + 5'd1;
            end
        end

        unique case (phase_next)
            PH_MAGIC: begin
                if (grp_done && phase_reg != PH_HEADER) begin
                    if (acc_sh[7:0] != want) begin
                        phase_next     = PH_DONE;
                        out_valid_next = 1'b1;
                        res_next       = '{decoded_byte: 8'd0, result_kind: KIND_BAD,
                                           is_last: 1'b1};
                    end else begin
                        magic_idx_next = magic_idx_next + 4'd1;
                        if (magic_idx_next >= sig_len) begin
                            phase_next = PH_EXTLEN;
                            acc_next   = 32'd0;
                        end
                    end
                end
            end
            PH_EXTLEN: begin
                if (grp_done) begin
                    remain_next = length_of(acc_sh);
                    acc_next    = 32'd0;
                    phase_next  = (remain_next != 31'd0) ? PH_EXT : PH_FILELEN;
                end
            end
            PH_EXT: begin
                if (grp_done) begin
                    remain_next    = remain_next - 31'd1;
                    out_valid_next = 1'b1;
                    res_next       = '{decoded_byte: acc_sh[7:0], result_kind: KIND_EXT,
                                       is_last: 1'b0};
                    if (remain_next == 31'd0) begin
                        phase_next = PH_FILELEN;
                        acc_next   = 32'd0;
                    end
                end
            end
            PH_FILELEN: begin
                if (grp_done) begin
                    remain_next = length_of(acc_sh);
                    acc_next    = 32'd0;
                    if (remain_next == 31'd0) begin
                        phase_next     = PH_DONE;
                        out_valid_next = 1'b1;
                        res_next       = '{decoded_byte: 8'd0, result_kind: KIND_EMPTY,
                                           is_last: 1'b1};
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (grp_done) begin
                    remain_next    = remain_next - 31'd1;
                    out_valid_next = 1'b1;
                    res_next       = '{decoded_byte: acc_sh[7:0], result_kind: KIND_DATA,
                                       is_last: (remain_next == 31'd0)};
                    if (remain_next == 31'd0) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
                // header, skip and done take no carrier bit
            end
        endcase

        byte_pos_next = byte_pos_next + 32'd1;
    end

    // parser state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            byte_pos_reg  <= 32'd0;
            pix_off_reg   <= 32'd0;
            acc_reg       <= 32'd0;
            bit_cnt_reg   <= 5'd0;
            remain_reg    <= 31'd0;
            magic_idx_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg     <= phase_next;
                byte_pos_reg  <= byte_pos_next;
                pix_off_reg   <= pix_off_next;
                acc_reg       <= acc_next;
                bit_cnt_reg   <= bit_cnt_next;
                remain_reg    <= remain_next;
                magic_idx_reg <= magic_idx_next;
                out_valid_reg <= out_valid_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && out_valid_next) begin
            res_reg <= res_next;
        end
    end

    // status results end the file and carry no character
    `BLPE_ASSERT_IMPLY(a_status_last, aclk, aresetn,
        out_valid_reg && (res_reg.result_kind == KIND_BAD || res_reg.result_kind == KIND_EMPTY),
        res_reg.is_last && res_reg.decoded_byte == 8'd0)
    // extension characters are never marked last
    `BLPE_ASSERT_IMPLY(a_ext_not_last, aclk, aresetn,
        out_valid_reg && res_reg.result_kind == KIND_EXT, !res_reg.is_last)
    // character phases count bits within one byte
    `BLPE_ASSERT_IMPLY(a_char_bitcnt, aclk, aresetn,
        phase_reg == PH_MAGIC || phase_reg == PH_EXT || phase_reg == PH_DATA,
        bit_cnt_reg < 5'd8)
    // a character phase always has characters left to read
    `BLPE_ASSERT_IMPLY(a_remain_nonzero, aclk, aresetn,
        phase_reg == PH_EXT || phase_reg == PH_DATA, remain_reg != 31'd0)
    // an idle parse stage produces no new result
    `BLPE_ASSERT_NEXT(a_no_spurious, aclk, aresetn,
        !in_valid_reg && !out_valid_reg, !out_valid_reg)

endmodule
